// ----- rtl/core/u8u16_pkg.sv -----
// ============================================================================
// u8u16_pkg - shared types and constants of the UTF-8 to UTF-16 transcoder
// Holds the job descriptor that travels from the decoder to the unit
// generator, and the code point constants that both sides use.
// ============================================================================
`default_nettype none

package u8u16_pkg;

   // Queue depth between the decoder and the unit generator.
   localparam int QUEUE_DEPTH = 4;

   localparam logic [15:0] REPLACEMENT_CHAR = 16'hFFFD;
   localparam logic [20:0] MAX_CODEPOINT    = 21'h10FFFF;
   localparam logic [20:0] BMP_MAX          = 21'h00FFFF;
   localparam logic [20:0] SURR_LOW_BOUND   = 21'h00D800;
   localparam logic [20:0] SURR_HIGH_BOUND  = 21'h00DFFF;
   localparam logic [20:0] SUPP_BASE        = 21'h010000;
   localparam logic [15:0] HIGH_SURR_BASE   = 16'hD800;
   localparam logic [15:0] LOW_SURR_BASE    = 16'hDC00;

   // Tail kinds of a job.
   localparam logic [1:0] TAIL_NONE   = 2'd0;
   localparam logic [1:0] TAIL_SINGLE = 2'd1;
   localparam logic [1:0] TAIL_PAIR   = 2'd2;

   // One decoded input byte: a run of replacement characters, followed by
   // an optional code point emitted as one unit or as a surrogate pair.
   typedef struct packed {
      logic [2:0]  rep_count;
      logic [1:0]  tail_count;
      logic [20:0] tail_cp;
      logic        string_end;
   } job_type;

endpackage

`default_nettype wire

// ----- rtl/core/utf8_to_utf16_transcoder.sv -----
// ============================================================================
// utf8_to_utf16_transcoder - UTF-8 to UTF-16 stream transcoder
// Takes UTF-8 bytes and gives UTF-16 code units, with surrogate pairs above
// the basic plane and one replacement character for each invalid byte.
// ============================================================================
//
// Channel   Direction  Beat contents
// -------   ---------  ----------------------------------------------------
// req_      in         text_byte, string_end (flag on the final byte)
// rsp_      out        code_unit, run_last (last unit of a byte),
//                      string_done (last unit of the string)
//
// The decoder takes one byte per cycle whenever the job queue has room; each
// byte turns into zero to four code units. The unit generator sends one code
// unit per cycle while the receiver is ready, so the sustained rate is one
// byte per cycle for bytes that give at most one unit, else the unit rate;
// the queue absorbs bursts. The first unit of a byte passes through the job
// queue and then the registered result stage before it is offered at the
// result port. Reset is synchronous and clears the open sequence, the queue
// and the result stage; there is no clearing pass. A stalled result beat
// holds its payload, and bytes keep flowing until the queue fills.
//
`default_nettype none

module utf8_to_utf16_transcoder #(
   parameter int QueueDepth = u8u16_pkg::QUEUE_DEPTH
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_valid,
   output logic        req_ready,
   input  wire  [7:0]  req_text_byte,
   input  wire         req_string_end,
   output logic        rsp_valid,
   input  wire         rsp_ready,
   output logic [15:0] rsp_code_unit,
   output logic        rsp_run_last,
   output logic        rsp_string_done
);
   import u8u16_pkg::*;

   // Decoder to queue.
   logic    push_valid;
   logic    push_ready;
   job_type push_job;

   // Queue to unit generator.
   logic    head_valid;
   logic    head_ready;
   job_type head_job;

   // The decoder owns the open-sequence state and the input handshake.
   u8u16_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_text_byte  (req_text_byte),
      .req_string_end (req_string_end),
      .job_valid      (push_valid),
      .job_ready      (push_ready),
      .job            (push_job)
   );

   // The queue lets the decoder run ahead while units of earlier bytes are
   // still being sent.
   u8u16_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (push_valid),
      .in_ready  (push_ready),
      .in_job    (push_job),
      .out_valid (head_valid),
      .out_ready (head_ready),
      .out_job   (head_job)
   );

   // The unit generator walks each job one code unit at a time into the
   // registered result stage.
   u8u16_back u_back (
      .clock           (clock),
      .reset           (reset),
      .job_valid       (head_valid),
      .job_ready       (head_ready),
      .job             (head_job),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_code_unit   (rsp_code_unit),
      .rsp_run_last    (rsp_run_last),
      .rsp_string_done (rsp_string_done)
   );

`ifndef NO_ASSERTIONS
   // Every queued job gives between one and four code units.
   a_job_units: assert property (@(posedge clock) disable iff (reset)
      push_valid |-> ((push_job.rep_count + {1'b0, push_job.tail_count}) != 3'd0) &&
                     ((push_job.rep_count + {1'b0, push_job.tail_count}) <= 3'd4))
      else $error("job with no units or more than four units");

   // A surrogate pair carries a supplementary code point.
   a_pair_range: assert property (@(posedge clock) disable iff (reset)
      (push_valid && (push_job.tail_count == TAIL_PAIR)) |->
         (push_job.tail_cp >= SUPP_BASE) && (push_job.tail_cp <= MAX_CODEPOINT))
      else $error("surrogate pair outside the supplementary planes");

   // A single unit is never a lone surrogate.
   a_single_range: assert property (@(posedge clock) disable iff (reset)
      (push_valid && (push_job.tail_count == TAIL_SINGLE)) |->
         (push_job.tail_cp <= BMP_MAX) &&
         ((push_job.tail_cp < SURR_LOW_BOUND) || (push_job.tail_cp > SURR_HIGH_BOUND)))
      else $error("single unit out of range or a surrogate");

   // The end of a string always closes the code units of its byte.
   a_done_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_string_done) |-> rsp_run_last)
      else $error("string end flagged on a unit that is not the last of its byte");

   // No result is offered straight after reset.
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result offered after reset");
`endif

endmodule

`default_nettype wire

// ----- rtl/core/u8u16_front.sv -----
// ============================================================================
// u8u16_front - byte decoder
// Accepts one UTF-8 byte per cycle while the queue has room, tracks the open
// sequence and turns each byte into a job descriptor for the unit generator.
// ============================================================================
`default_nettype none

module u8u16_front (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_valid,
   output logic                 req_ready,
   input  wire  [7:0]           req_text_byte,
   input  wire                  req_string_end,
   output logic                 job_valid,
   input  wire                  job_ready,
   output u8u16_pkg::job_type   job
);
   import u8u16_pkg::*;

   typedef enum logic [2:0] {
      LEAD_ASCII = 3'd0,
      LEAD_TWO   = 3'd1,
      LEAD_THREE = 3'd2,
      LEAD_FOUR  = 3'd3,
      LEAD_BAD   = 3'd4
   } lead_class_type;

   logic [2:0]     exp_len_ff, exp_len_in;
   logic [1:0]     pend_cnt_ff, pend_cnt_in;
   logic [20:0]    part_cp_ff, part_cp_in;

   lead_class_type lead_class;
   logic [2:0]     lead_len;
   logic [20:0]    lead_cp;
   logic           accept;
   logic           is_open;
   logic           is_cont;
   logic [20:0]    acc_cp;
   logic [2:0]     acc_cnt;
   logic [2:0]     rep;
   logic [1:0]     tail;
   logic [20:0]    tail_cp;
   logic [2:0]     unit_total;

   assign req_ready = job_ready;
   assign accept    = req_valid && job_ready;

   // Lead byte classification.
   always_comb begin
      lead_class = LEAD_BAD;
      lead_len   = 3'd0;
      lead_cp    = 21'd0;
      if (req_text_byte[7] == 1'b0) begin
         lead_class = LEAD_ASCII;
         lead_cp    = {13'd0, req_text_byte};
      end else if (req_text_byte[7:5] == 3'b110) begin
         lead_class = LEAD_TWO;
         lead_len   = 3'd2;
         lead_cp    = {16'd0, req_text_byte[4:0]};
      end else if (req_text_byte[7:4] == 4'b1110) begin
         lead_class = LEAD_THREE;
         lead_len   = 3'd3;
         lead_cp    = {17'd0, req_text_byte[3:0]};
      end else if (req_text_byte[7:3] == 5'b11110) begin
         lead_class = LEAD_FOUR;
         lead_len   = 3'd4;
         lead_cp    = {18'd0, req_text_byte[2:0]};
      end
   end

   assign is_open = (exp_len_ff != 3'd0);
   assign is_cont = (req_text_byte[7:6] == 2'b10);
   assign acc_cp  = {part_cp_ff[14:0], req_text_byte[5:0]};
   assign acc_cnt = {1'b0, pend_cnt_ff} + 3'd1;

   always_comb begin
      rep         = 3'd0;
      tail        = TAIL_NONE;
      tail_cp     = 21'd0;
      exp_len_in  = exp_len_ff;
      pend_cnt_in = pend_cnt_ff;
      part_cp_in  = part_cp_ff;
      if (is_open && is_cont) begin
         if ((acc_cnt + 3'd1) >= exp_len_ff) begin
            exp_len_in  = 3'd0;
            pend_cnt_in = 2'd0;
            if ((acc_cp > MAX_CODEPOINT) ||
                ((acc_cp >= SURR_LOW_BOUND) && (acc_cp <= SURR_HIGH_BOUND))) begin
               rep = exp_len_ff;
            end else begin
               tail    = (acc_cp > BMP_MAX) ? TAIL_PAIR : TAIL_SINGLE;
               tail_cp = acc_cp;
            end
         end else if (req_string_end) begin
            // A sequence cut at string end gives one replacement for the lead
            // and one for each continuation, this byte included.
            rep         = acc_cnt + 3'd1;
            exp_len_in  = 3'd0;
            pend_cnt_in = 2'd0;
         end else begin
            pend_cnt_in = acc_cnt[1:0];
            part_cp_in  = acc_cp;
         end
      end else begin
         // A broken sequence yields one replacement per byte seen so far;
         // the breaking byte is then decoded as a lead.
         if (is_open) begin
            rep         = acc_cnt;
            exp_len_in  = 3'd0;
            pend_cnt_in = 2'd0;
         end
         case (lead_class)
            LEAD_ASCII: begin
               tail    = TAIL_SINGLE;
               tail_cp = lead_cp;
            end
            LEAD_TWO, LEAD_THREE, LEAD_FOUR: begin
               if (req_string_end) begin
                  rep = rep + 3'd1;
               end else begin
                  exp_len_in  = lead_len;
                  pend_cnt_in = 2'd0;
                  part_cp_in  = lead_cp;
               end
            end
            default: begin
               rep = rep + 3'd1;
            end
         endcase
      end
      if (req_string_end) begin
         exp_len_in  = 3'd0;
         pend_cnt_in = 2'd0;
      end
   end

   assign unit_total = rep + {1'b0, tail};
   assign job_valid  = accept && (unit_total != 3'd0);

   always_comb begin
      job.rep_count  = rep;
      job.tail_count = tail;
      job.tail_cp    = tail_cp;
      job.string_end = req_string_end;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         exp_len_ff  <= 3'd0;
         pend_cnt_ff <= 2'd0;
      end else if (accept) begin
         exp_len_ff  <= exp_len_in;
         pend_cnt_ff <= pend_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         part_cp_ff <= part_cp_in;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/core/u8u16_queue.sv -----
// ============================================================================
// u8u16_queue - job queue
// A small first-in first-out store of job descriptors between the decoder
// and the unit generator.
// ============================================================================
`default_nettype none

module u8u16_queue #(
   parameter int Depth = u8u16_pkg::QUEUE_DEPTH
) (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  in_valid,
   output logic                 in_ready,
   input  u8u16_pkg::job_type   in_job,
   output logic                 out_valid,
   input  wire                  out_ready,
   output u8u16_pkg::job_type   out_job
);
   import u8u16_pkg::*;

   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);
   localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
   localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

   job_type           mem_ff [Depth];
   logic [PtrW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]   count_ff, count_in;
   logic              push;
   logic              pop;

   assign in_ready  = (count_ff != FullCnt);
   assign out_valid = (count_ff != '0);
   assign out_job   = mem_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + PtrW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + PtrW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CntW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CntW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= in_job;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/core/u8u16_back.sv -----
// ============================================================================
// u8u16_back - unit generator
// Expands the job at the head of the queue into UTF-16 code units, one per
// cycle while the receiver is ready, into the registered result stage.
// ============================================================================
`default_nettype none

module u8u16_back (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  job_valid,
   output logic                 job_ready,
   input  u8u16_pkg::job_type   job,
   output logic                 rsp_valid,
   input  wire                  rsp_ready,
   output logic [15:0]          rsp_code_unit,
   output logic                 rsp_run_last,
   output logic                 rsp_string_done
);
   import u8u16_pkg::*;

   logic [1:0]  unit_idx_ff, unit_idx_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [15:0] code_unit_ff;
   logic        run_last_ff;
   logic        string_done_ff;

   logic [2:0]  unit_total;
   logic        is_last;
   logic        load;
   logic [2:0]  tail_pos;
   logic [20:0] supp_offset;
   logic [15:0] high_surr;
   logic [15:0] low_surr;
   logic [15:0] unit_value;

   assign unit_total  = job.rep_count + {1'b0, job.tail_count};
   assign is_last     = (({1'b0, unit_idx_ff} + 3'd1) == unit_total);
   assign load        = job_valid && (!rsp_valid_ff || rsp_ready);
   assign job_ready   = load && is_last;

   assign tail_pos    = {1'b0, unit_idx_ff} - job.rep_count;
   assign supp_offset = job.tail_cp - SUPP_BASE;
   assign high_surr   = HIGH_SURR_BASE + {6'd0, supp_offset[19:10]};
   assign low_surr    = LOW_SURR_BASE + {6'd0, supp_offset[9:0]};

   // Replacements come first, then the code point.
   always_comb begin
      if ({1'b0, unit_idx_ff} < job.rep_count) begin
         unit_value = REPLACEMENT_CHAR;
      end else if (tail_pos[0]) begin
         unit_value = low_surr;
      end else if (job.tail_count == TAIL_PAIR) begin
         unit_value = high_surr;
      end else begin
         unit_value = job.tail_cp[15:0];
      end
   end

   always_comb begin
      unit_idx_in  = unit_idx_ff;
      rsp_valid_in = rsp_valid_ff;
      if (load) begin
         unit_idx_in  = is_last ? 2'd0 : unit_idx_ff + 2'd1;
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         unit_idx_ff  <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         unit_idx_ff  <= unit_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         code_unit_ff   <= unit_value;
         run_last_ff    <= is_last;
         string_done_ff <= is_last && job.string_end;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_code_unit   = code_unit_ff;
   assign rsp_run_last    = run_last_ff;
   assign rsp_string_done = string_done_ff;

endmodule

`default_nettype wire

// ----- sim/utf8_to_utf16_transcoder_test.sv -----
// ============================================================================
// utf8_to_utf16_transcoder_test - self-checking bench for the UTF-8 transcoder
// Feeds UTF-8 byte beats through the request channel and checks every UTF-16
// unit beat against a behavioural decoder kept inside the bench. A directed
// opening covers each decoding corner; random strings of mostly well-formed
// characters, with cut and corrupted sequences mixed in, follow. Both sides
// stall at random, and the receiver holds off once for long enough to fill
// the block and stall its input.
// ============================================================================

module utf8_to_utf16_transcoder_test;

   import u8u16_pkg::*;

   // Byte classes of UTF-8.
   localparam logic [7:0] CONT_MASK  = 8'hC0;
   localparam logic [7:0] CONT_TAG   = 8'h80;
   localparam logic [7:0] LEAD2_MASK = 8'hE0;
   localparam logic [7:0] LEAD2_TAG  = 8'hC0;
   localparam logic [7:0] LEAD3_MASK = 8'hF0;
   localparam logic [7:0] LEAD3_TAG  = 8'hE0;
   localparam logic [7:0] LEAD4_MASK = 8'hF8;
   localparam logic [7:0] LEAD4_TAG  = 8'hF0;

   // Run shape.
   localparam int IDLE_PERCENT = 28;
   localparam int RANDOM_BYTES = 300;
   localparam int HOLD_AT      = 60;    // beats taken before the long hold-off
   localparam int HOLD_CYCLES  = 80;
   localparam int CALM_FROM    = 180;   // window of beats with no idling at all
   localparam int CALM_UNTIL   = 250;
   localparam int DRAIN_CYCLES = 20;
   localparam int PRINT_LIMIT  = 40;
   localparam int TIMEOUT      = 400000;

   typedef struct packed {
      logic [7:0] text_byte;
      logic       string_end;
   } utf8_beat_type;

   typedef struct packed {
      logic [15:0] code_unit;
      logic        run_last;
      logic        string_done;
   } utf16_unit_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_text_byte = '0;
   logic        req_string_end = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [15:0] rsp_code_unit;
   logic        rsp_run_last;
   logic        rsp_string_done;

   utf8_beat_type  byte_queue [$];       // bytes still to be offered
   utf16_unit_type expected_units [$];   // units predicted but not yet seen
   logic [15:0]    units_now [$];        // units caused by the byte being decoded

   int          total_bytes = 0;
   int          bytes_taken = 0;
   int          mismatch_count = 0;

   // Decoder state: length of the open sequence (zero when none is open), the
   // continuation bytes taken so far, and the code point bits gathered.
   logic [2:0]  seq_len = '0;
   logic [1:0]  cont_seen = '0;
   logic [20:0] cp_acc = '0;

   logic        calm;
   int          hold_left = 0;
   logic        hold_done = 1'b0;

   assign calm = (bytes_taken >= CALM_FROM) && (bytes_taken < CALM_UNTIL);

   utf8_to_utf16_transcoder DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_text_byte   (req_text_byte),
      .req_string_end  (req_string_end),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_code_unit   (rsp_code_unit),
      .rsp_run_last    (rsp_run_last),
      .rsp_string_done (rsp_string_done)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
   end

   // A hung block must not run for ever: the limit is several times the
   // slowest correct run, with four units per byte and every stall at its
   // longest.
   initial begin
      #TIMEOUT;
      $display("Mismatches found");
      $finish;
   end

   task automatic report_mismatch(input string what);
      if (mismatch_count < PRINT_LIMIT) begin
         $display("[%0t] mismatch: %s", $realtime, what);
      end
      mismatch_count++;
   endtask

   // ------------------------------------------------------------------------
   // Behavioural decoder
   // ------------------------------------------------------------------------

   task automatic add_unit(input logic [15:0] value);
      units_now.insert(units_now.size(), value);
   endtask

   task automatic emit_codepoint(input logic [20:0] cp);
      logic [20:0] offset;
      if (cp <= BMP_MAX) begin
         add_unit(cp[15:0]);
      end else begin
         offset = cp - SUPP_BASE;
         add_unit(HIGH_SURR_BASE + 16'(offset[19:10]));
         add_unit(LOW_SURR_BASE + 16'(offset[9:0]));
      end
   endtask

   task automatic emit_replacements(input int count);
      for (int k = 0; k < count; k++) begin
         add_unit(REPLACEMENT_CHAR);
      end
   endtask

   // Decodes a byte that stands where a lead byte is expected. A multi-byte
   // lead opens a sequence, unless it is itself the last byte of the string,
   // in which case it is cut at once and becomes one replacement.
   task automatic take_lead(input logic [7:0] b, input logic fin);
      logic [2:0]  len;
      logic [20:0] cp;
      len = '0;
      cp  = '0;
      if (!b[7]) begin
         add_unit({8'h00, b});
      end else if ((b & LEAD2_MASK) == LEAD2_TAG) begin
         len = 3'd2;
         cp  = 21'(b[4:0]);
      end else if ((b & LEAD3_MASK) == LEAD3_TAG) begin
         len = 3'd3;
         cp  = 21'(b[3:0]);
      end else if ((b & LEAD4_MASK) == LEAD4_TAG) begin
         len = 3'd4;
         cp  = 21'(b[2:0]);
      end else begin
         add_unit(REPLACEMENT_CHAR);
      end
      if (len != 0) begin
         if (fin) begin
            add_unit(REPLACEMENT_CHAR);
         end else begin
            seq_len   = len;
            cont_seen = '0;
            cp_acc    = cp;
         end
      end
   endtask

   // Works out the unit beats that one accepted byte causes and queues them.
   task automatic predict_units(input logic [7:0] b, input logic fin);
      utf16_unit_type unit;
      int             taken;
      if (seq_len != 0) begin
         if ((b & CONT_MASK) == CONT_TAG) begin
            cp_acc = {cp_acc[14:0], b[5:0]};
            cont_seen++;
            taken = int'(cont_seen) + 1;
            if (taken >= int'(seq_len)) begin
               // Surrogate values and values past the last plane are
               // rejected byte by byte, overlong forms are let through.
               if (cp_acc > MAX_CODEPOINT ||
                   (cp_acc >= SURR_LOW_BOUND && cp_acc <= SURR_HIGH_BOUND)) begin
                  emit_replacements(int'(seq_len));
               end else begin
                  emit_codepoint(cp_acc);
               end
               seq_len = '0;
            end else if (fin) begin
               emit_replacements(taken);
               seq_len = '0;
            end
         end else begin
            // The breaking byte costs the open sequence one replacement per
            // byte so far and is then decoded again as a lead.
            emit_replacements(int'(cont_seen) + 1);
            seq_len = '0;
            take_lead(b, fin);
         end
      end else begin
         take_lead(b, fin);
      end
      if (fin || seq_len == 0) begin
         seq_len   = '0;
         cont_seen = '0;
         cp_acc    = '0;
      end
      foreach (units_now[k]) begin
         unit.code_unit   = units_now[k];
         unit.run_last    = (k == units_now.size() - 1);
         unit.string_done = unit.run_last && fin;
         expected_units.insert(expected_units.size(), unit);
      end
      units_now.delete();
   endtask

   // ------------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------------

   task automatic add_byte(input logic [7:0] b, input logic fin);
      utf8_beat_type beat;
      beat.text_byte  = b;
      beat.string_end = fin;
      byte_queue.insert(byte_queue.size(), beat);
      total_bytes++;
   endtask

   // One character of a random string: mostly well formed with random
   // content, sometimes a stray byte, a sequence cut short or a sequence
   // whose continuations are replaced by arbitrary bytes.
   task automatic add_random_char(input logic fin);
      int         roll;
      int         len;
      int         sent;
      logic [7:0] b;
      roll = $urandom_range(99);
      if (roll < 8) begin
         add_byte(8'($urandom_range(255)), fin);
      end else begin
         len = $urandom_range(1, 4);
         case (len)
            1: b = 8'($urandom_range(127));
            2: b = LEAD2_TAG | 8'($urandom_range(31));
            3: b = LEAD3_TAG | 8'($urandom_range(15));
            default: b = LEAD4_TAG | 8'(($urandom_range(9) == 0) ?
                                        $urandom_range(7) : $urandom_range(4));
         endcase
         sent = len;
         if (roll < 18 && len > 1) begin
            sent = $urandom_range(1, len - 1);
         end
         add_byte(b, fin && sent == 1);
         for (int k = 1; k < sent; k++) begin
            if (roll >= 18 && roll < 26) begin
               b = 8'($urandom_range(255));
            end else begin
               b = CONT_TAG | 8'($urandom_range(63));
            end
            add_byte(b, fin && k == sent - 1);
         end
      end
   endtask

   initial begin
      int chars;

      // Plain ASCII, both ends of the range, the second closing a string.
      add_byte(8'h00, 1'b0);
      add_byte(8'h7F, 1'b1);
      // Two- and three-byte characters.
      add_byte(8'hC3, 1'b0);
      add_byte(8'hA9, 1'b0);
      add_byte(8'hE2, 1'b0);
      add_byte(8'h82, 1'b0);
      add_byte(8'hAC, 1'b1);
      // The highest code point, which comes out as a surrogate pair.
      add_byte(8'hF4, 1'b0);
      add_byte(8'h8F, 1'b0);
      add_byte(8'hBF, 1'b0);
      add_byte(8'hBF, 1'b0);
      // An encoded surrogate: one replacement per byte.
      add_byte(8'hED, 1'b0);
      add_byte(8'hA0, 1'b0);
      add_byte(8'h80, 1'b0);
      // A value beyond the last plane from a lead above 0xF4.
      add_byte(8'hF7, 1'b0);
      add_byte(8'hBF, 1'b0);
      add_byte(8'hBF, 1'b0);
      add_byte(8'hBF, 1'b1);
      // Bad leads: a lone continuation byte and a byte that is never valid.
      add_byte(8'h80, 1'b0);
      add_byte(8'hFF, 1'b0);
      // A sequence broken by an ASCII byte, which is then decoded in its own
      // right.
      add_byte(8'hE2, 1'b0);
      add_byte(8'h41, 1'b0);
      // A sequence cut at the end of the string.
      add_byte(8'hE2, 1'b0);
      add_byte(8'h82, 1'b1);
      // A lead byte that itself ends the string.
      add_byte(8'hF0, 1'b1);
      // A sequence broken by a bad lead that ends the string.
      add_byte(8'hC3, 1'b0);
      add_byte(8'hFF, 1'b1);

      while (total_bytes < 27 + RANDOM_BYTES) begin
         chars = $urandom_range(1, 6);
         for (int k = 0; k < chars; k++) begin
            add_random_char(k == chars - 1);
         end
      end

      // Polling on the falling edge keeps the end test clear of the updates
      // made at the rising edge.
      @(negedge clock);
      while (bytes_taken != total_bytes) @(negedge clock);
      while (expected_units.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   // ------------------------------------------------------------------------
   // Request driver
   // ------------------------------------------------------------------------

   // A new byte beat is presented only once the previous one has been taken,
   // so valid and payload hold steady while the block is not ready.
   always @(posedge clock) begin : drive_requests
      utf8_beat_type next_beat;
      if (reset) begin
         req_valid      <= 1'b0;
         req_text_byte  <= '0;
         req_string_end <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (byte_queue.size() != 0 && (calm || $urandom_range(99) >= IDLE_PERCENT)) begin
            next_beat = byte_queue.pop_front();
            req_valid      <= 1'b1;
            req_text_byte  <= next_beat.text_byte;
            req_string_end <= next_beat.string_end;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Result receiver
   // ------------------------------------------------------------------------

   // Random back-pressure, plus one long hold-off while the sender keeps
   // offering bytes, so that the queue inside the block fills and it has to
   // stall its input.
   always @(posedge clock) begin : drive_ready
      if (reset) begin
         rsp_ready <= 1'b0;
         hold_left <= 0;
         hold_done <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (!hold_done && bytes_taken >= HOLD_AT) begin
         rsp_ready <= 1'b0;
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
      end else begin
         rsp_ready <= calm || ($urandom_range(99) >= IDLE_PERCENT);
      end
   end

   // ------------------------------------------------------------------------
   // Monitor
   // ------------------------------------------------------------------------

   // Both channels are watched here: an accepted byte beat is decoded into
   // its expected units first, then an accepted unit beat is checked against
   // the oldest expectation.
   always @(posedge clock) begin : watch_channels
      utf16_unit_type want;
      if (!reset) begin
         if (req_valid && req_ready) begin
            predict_units(req_text_byte, req_string_end);
            bytes_taken <= bytes_taken + 1;
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_units.size() == 0) begin
               report_mismatch($sformatf("unit %h arrived with none expected",
                                         rsp_code_unit));
            end else begin
               want = expected_units.pop_front();
               if (rsp_code_unit !== want.code_unit) begin
                  report_mismatch($sformatf("code_unit %h, expected %h",
                                            rsp_code_unit, want.code_unit));
               end
               if (rsp_run_last !== want.run_last) begin
                  report_mismatch($sformatf("run_last %b, expected %b on unit %h",
                                            rsp_run_last, want.run_last,
                                            want.code_unit));
               end
               if (rsp_string_done !== want.string_done) begin
                  report_mismatch($sformatf("string_done %b, expected %b on unit %h",
                                            rsp_string_done, want.string_done,
                                            want.code_unit));
               end
            end
         end
      end
   end

endmodule
